@@ rtl/lse_pkg.sv @@
// shared types and constants of the lsb stego extractor
package lse_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCRYPTED = 1'd1;

  // extraction modes, the unused code behaves as one lsb
  localparam logic [1:0] MODE_LSB1 = 2'd0;
  localparam logic [1:0] MODE_LSB4 = 2'd1;
  localparam logic [1:0] MODE_LSBI = 2'd2;

  localparam int unsigned HDR_BYTES     = 4;
  localparam int unsigned TRAILER_BYTES = 5;
  localparam int unsigned FLIP_BITS     = 4;
  localparam int unsigned COUNT_W       = 33;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last;
  } lse_res_t;

endpackage

@@ rtl/lse_in_if.sv @@
// input channel: carrier component bytes
interface lse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] carrier_byte;
  logic       first;

  modport source (output valid, output carrier_byte, output first, input ready);
  modport sink   (input valid, input carrier_byte, input first, output ready);
endinterface

@@ rtl/lse_out_if.sv @@
// result channel: recovered payload bytes
interface lse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output payload_byte, output last, input ready);
  modport sink   (input valid, input payload_byte, input last, output ready);
endinterface

@@ rtl/lse_extract.sv @@
// input register, configuration registers and the bit extraction state
module lse_extract (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_carrier_byte,
  input  logic                      in_first,
  input  logic                      res_room,
  output logic                      res_valid,
  output lse_pkg::lse_res_t         res
);
  import lse_pkg::*;

  logic [1:0]         mode_r;
  logic               encrypted_r;

  logic               in_valid_r;
  logic [7:0]         carrier_r;
  logic               first_r;

  logic [2:0]         mask_phase_r, mask_phase_nxt;
  logic [3:0]         class_flips_r, class_flips_nxt;
  logic [7:0]         shift_byte_r, shift_byte_nxt;
  logic [2:0]         bits_held_r, bits_held_nxt;
  logic [COUNT_W-1:0] bytes_out_r, bytes_out_nxt;
  logic [31:0]        length_header_r, length_header_nxt;
  logic               finished_r, finished_nxt;

  // state seen by this component after an optional restart
  logic [2:0]         mask_phase_b;
  logic [3:0]         class_flips_b;
  logic [7:0]         shift_byte_b;
  logic [2:0]         bits_held_b;
  logic [COUNT_W-1:0] bytes_out_b;
  logic [31:0]        length_header_b;
  logic               finished_b;

  logic               proc;
  logic               byte_done;
  logic [7:0]         new_shift;
  logic               bit_in;
  logic [COUNT_W-1:0] total;

  assign proc     = in_valid_r && res_room;
  assign in_ready = !in_valid_r || res_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_LSB1;
      encrypted_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:      mode_r      <= cfg_wdata;
        CFG_ENCRYPTED: encrypted_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      carrier_r <= in_carrier_byte;
      first_r   <= in_first;
    end
  end

  always_comb begin
    if (first_r) begin
      mask_phase_b    = '0;
      class_flips_b   = '0;
      shift_byte_b    = '0;
      bits_held_b     = '0;
      bytes_out_b     = '0;
      length_header_b = '0;
      finished_b      = 1'b0;
    end else begin
      mask_phase_b    = mask_phase_r;
      class_flips_b   = class_flips_r;
      shift_byte_b    = shift_byte_r;
      bits_held_b     = bits_held_r;
      bytes_out_b     = bytes_out_r;
      length_header_b = length_header_r;
      finished_b      = finished_r;
    end
  end

  always_comb begin
    mask_phase_nxt    = mask_phase_b;
    class_flips_nxt   = class_flips_b;
    shift_byte_nxt    = shift_byte_b;
    bits_held_nxt     = bits_held_b;
    bytes_out_nxt     = bytes_out_b;
    length_header_nxt = length_header_b;
    finished_nxt      = finished_b;
    byte_done         = 1'b0;
    new_shift         = shift_byte_b;
    bit_in            = carrier_r[0];
    total             = '0;
    res_valid         = 1'b0;
    res.payload_byte  = new_shift;
    res.last          = 1'b0;

    if (!finished_b) begin
      case (mode_r)
        MODE_LSB4: begin
          // past four bits held only the top bits that complete the byte are taken
          case (bits_held_b)
            3'd5: begin
              new_shift = {shift_byte_b[4:0], carrier_r[3:1]};
              byte_done = 1'b1;
            end
            3'd6: begin
              new_shift = {shift_byte_b[5:0], carrier_r[3:2]};
              byte_done = 1'b1;
            end
            3'd7: begin
              new_shift = {shift_byte_b[6:0], carrier_r[3]};
              byte_done = 1'b1;
            end
            default: begin
              new_shift = {shift_byte_b[3:0], carrier_r[3:0]};
              byte_done = (bits_held_b == 3'd4);
            end
          endcase
          bits_held_nxt = byte_done ? 3'd0 : bits_held_b + 3'd4;
        end
        MODE_LSBI: begin
          if (mask_phase_b < 3'(FLIP_BITS)) begin
            if (carrier_r[0]) begin
              class_flips_nxt = class_flips_b | (4'd1 << mask_phase_b[1:0]);
            end
            mask_phase_nxt = mask_phase_b + 3'd1;
          end else begin
            bit_in        = carrier_r[0] ^ class_flips_b[carrier_r[2:1]];
            new_shift     = {shift_byte_b[6:0], bit_in};
            byte_done     = (bits_held_b == 3'd7);
            bits_held_nxt = bits_held_b + 3'd1;
          end
        end
        default: begin
          new_shift     = {shift_byte_b[6:0], bit_in};
          byte_done     = (bits_held_b == 3'd7);
          bits_held_nxt = bits_held_b + 3'd1;
        end
      endcase

      shift_byte_nxt = new_shift;
      if (byte_done) begin
        if (bytes_out_b < COUNT_W'(HDR_BYTES)) begin
          length_header_nxt = {length_header_b[23:0], new_shift};
        end
        bytes_out_nxt    = bytes_out_b + COUNT_W'(1);
        total            = {1'b0, length_header_nxt}
                         + (encrypted_r ? COUNT_W'(HDR_BYTES)
                                        : COUNT_W'(HDR_BYTES + TRAILER_BYTES));
        res.last         = (bytes_out_nxt >= COUNT_W'(HDR_BYTES)) && (bytes_out_nxt >= total);
        finished_nxt     = res.last;
        shift_byte_nxt   = '0;
        res_valid        = proc;
        res.payload_byte = new_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_phase_r    <= '0;
      class_flips_r   <= '0;
      shift_byte_r    <= '0;
      bits_held_r     <= '0;
      bytes_out_r     <= '0;
      length_header_r <= '0;
      finished_r      <= 1'b0;
    end else if (proc) begin
      mask_phase_r    <= mask_phase_nxt;
      class_flips_r   <= class_flips_nxt;
      shift_byte_r    <= shift_byte_nxt;
      bits_held_r     <= bits_held_nxt;
      bytes_out_r     <= bytes_out_nxt;
      length_header_r <= length_header_nxt;
      finished_r      <= finished_nxt;
    end
  end

endmodule

@@ rtl/lse_out_buf.sv @@
// result register with a skid entry so the input side keeps moving under stall
module lse_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  lse_pkg::lse_res_t res,
  output logic              res_room,
  output logic              out_valid,
  input  logic              out_ready,
  output lse_pkg::lse_res_t out_res
);
  import lse_pkg::*;

  logic     main_valid_r;
  lse_res_t main_r;
  logic     skid_valid_r;
  lse_res_t skid_r;
  logic     main_free;

  assign res_room  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;
  assign main_free = !main_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

endmodule

@@ rtl/lsb_stego_extractor_core.sv @@
// top level of the lsb stego extractor
//
//  channel  | dir | transfer      | payload
//  in_if    | in  | valid & ready | carrier_byte[7:0], first
//  out_if   | out | valid & ready | payload_byte[7:0], last
//  cfg_*    | in  | cfg_we        | cfg_index[0], cfg_wdata[1:0]
//
// one component is taken every cycle while the result side has room; a recovered byte
// passes through the input register, then the result register, on its way to out_if
// the extraction state is read and written back in the same cycle, which sets that rate
// synchronous active-low reset clears config to lsb1, unencrypted, and a fresh start
// with out_if stalled the skid entry absorbs one more byte before in_if.ready drops
module lsb_stego_extractor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  lse_in_if.sink                          in_if,
  lse_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [lse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lse_pkg::*;

  logic     res_valid;
  logic     res_room;
  logic     in_ready;
  lse_res_t res;
  lse_res_t out_res;
  logic     out_valid;

  lse_extract u_extract (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_if.valid),
    .in_ready        (in_ready),
    .in_carrier_byte (in_if.carrier_byte),
    .in_first        (in_if.first),
    .res_room        (res_room),
    .res_valid       (res_valid),
    .res             (res)
  );

  lse_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .out_res   (out_res)
  );

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid;
  assign out_if.payload_byte = out_res.payload_byte;
  assign out_if.last         = out_res.last;

endmodule

@@ rtl/lse_checker.sv @@
// port-level checks of the lsb stego extractor and their binding
module lse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic       out_last
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) && $stable(out_last))
    else $error("stalled result changed");

  // input only backs up when a result is waiting
  a_ready_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // a request taken with the skid full cannot happen: once ready has dropped it
  // stays low while the output stays stalled
  a_skid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready |=> !in_ready)
    else $error("input accepted while output buffer full");

endmodule

bind lsb_stego_extractor_core lse_checker u_lse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_payload_byte (out_if.payload_byte),
  .out_last         (out_if.last)
);

@@ bench/tb_top.sv @@
// testbench of the lsb stego extractor core: scoreboard, drivers and stimulus
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lse_pkg::*;

  localparam int ITEM_TARGET  = 1500;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } comp_t;

  // tracks extraction state and holds the payload bytes still to come out
  class extract_scoreboard;
    logic [1:0]      mode;
    logic            encrypted;
    int unsigned     flips_read;
    logic [3:0]      class_flips;
    logic [7:0]      shift_byte;
    int unsigned     bits_held;
    longint unsigned bytes_out;
    logic [31:0]     length_header;
    bit              finished;
    lse_res_t        expected_q[$];
    int              mismatches;

    function new();
      mode       = MODE_LSB1;
      encrypted  = 1'b0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      flips_read    = 0;
      class_flips   = '0;
      shift_byte    = '0;
      bits_held     = 0;
      bytes_out     = 0;
      length_header = '0;
      finished      = 1'b0;
    endfunction

    function bit push_bit(logic b);
      shift_byte = {shift_byte[6:0], b};
      bits_held++;
      if (bits_held >= 8) begin
        bits_held = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void emit_byte();
      lse_res_t        res;
      longint unsigned total;
      res.payload_byte = shift_byte;
      res.last         = 1'b0;
      if (bytes_out < HDR_BYTES) length_header = {length_header[23:0], shift_byte};
      bytes_out = (bytes_out + 1) & 64'h1_FFFF_FFFF;
      total = HDR_BYTES + longint'(length_header) + (encrypted ? 0 : TRAILER_BYTES);
      if (bytes_out >= HDR_BYTES && bytes_out >= total) begin
        res.last = 1'b1;
        finished = 1'b1;
      end
      shift_byte = '0;
      expected_q.push_back(res);
    endfunction

    function void note_component(logic [7:0] c, logic first);
      bit          done;
      int unsigned n;
      done = 1'b0;
      if (first) restart();
      if (finished) return;
      case (mode)
        MODE_LSB4: begin
          n = (bits_held > 4) ? 8 - bits_held : 4;
          for (int k = 0; k < n; k++)
            if (push_bit(c[3-k])) done = 1'b1;
        end
        MODE_LSBI: begin
          if (flips_read < FLIP_BITS) begin
            if (c[0]) class_flips[flips_read] = 1'b1;
            flips_read++;
            return;
          end
          done = push_bit(c[0] ^ class_flips[c[2:1]]);
        end
        default: done = push_bit(c[0]);
      endcase
      if (done) emit_byte();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
    endfunction

    function void check_byte(lse_res_t got);
      lse_res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", got.payload_byte, got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.payload_byte !== want.payload_byte)
        report($sformatf("payload_byte expected %02h got %02h",
                         want.payload_byte, got.payload_byte));
      if (got.last !== want.last)
        report($sformatf("last expected %0b got %0b (byte %02h)",
                         want.last, got.last, want.payload_byte));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lse_in_if  in_ch();
  lse_out_if out_ch();

  lsb_stego_extractor_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  extract_scoreboard sb = new();

  logic [7:0] payload_q[$];
  comp_t      carrier_q[$];
  int         items_sent;
  int         in_idle_max;
  int         out_idle_max;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // stalls on the result side
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, out_idle_max);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    lse_res_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.payload_byte = out_ch.payload_byte;
        got.last         = out_ch.last;
        sb.check_byte(got);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_component(logic [7:0] c, logic first);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.carrier_byte <= c;
    in_ch.first        <= first;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_component(c, first);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_carrier();
    foreach (carrier_q[i]) send_component(carrier_q[i].data, carrier_q[i].first);
    carrier_q.delete();
  endtask

  // hold off the sender until every pending byte is out and the pipe is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(logic [1:0] m, logic [1:0] enc_raw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_index <= CFG_ENCRYPTED;
    cfg_wdata <= enc_raw;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.mode      = m;
    sb.encrypted = enc_raw[0];
  endtask

  // header, body and, when unencrypted and not cut short, the trailer; huge lengths are cut short
  function automatic void build_payload(logic [31:0] length, logic enc);
    int unsigned body;
    payload_q.delete();
    for (int i = 3; i >= 0; i--) payload_q.push_back(length[8*i +: 8]);
    body = (length > 20) ? 20 : length;
    for (int i = 0; i < body; i++) payload_q.push_back(8'($urandom));
    if (length <= 20 && !enc)
      for (int i = 0; i < TRAILER_BYTES; i++) payload_q.push_back(8'($urandom));
  endfunction

  function automatic void encode_payload(logic [1:0] m, logic lead_first);
    logic [3:0] flips;
    logic [7:0] c;
    logic       f;
    f = lead_first;
    if (m == MODE_LSBI) begin
      for (int i = 0; i < FLIP_BITS; i++) begin
        c = 8'($urandom);
        flips[i] = c[0];
        carrier_q.push_back({c, f});
        f = 1'b0;
      end
    end
    foreach (payload_q[j]) begin
      if (m == MODE_LSB4) begin
        for (int h = 1; h >= 0; h--) begin
          c = 8'($urandom);
          c[3:0] = payload_q[j][4*h +: 4];
          carrier_q.push_back({c, f});
          f = 1'b0;
        end
      end else begin
        for (int b = 7; b >= 0; b--) begin
          c = 8'($urandom);
          if (m == MODE_LSBI) c[0] = payload_q[j][b] ^ flips[c[2:1]];
          else c[0] = payload_q[j][b];
          carrier_q.push_back({c, f});
          f = 1'b0;
        end
      end
    end
  endfunction

  function automatic logic [31:0] pick_length(logic [1:0] m);
    case ($urandom_range(0, 15))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'hFFFF_FFFB;
      2:       return $urandom;
      default: return $urandom_range(0, (m == MODE_LSB4) ? 16 : 8);
    endcase
  endfunction

  initial begin
    logic [1:0] m;
    logic [1:0] enc_raw;
    int         phase;
    int         kind;
    int         cut;
    int         n;
    logic       lead;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.carrier_byte = '0;
    in_ch.first        = 1'b0;
    out_ch.ready       = 1'b0;
    items_sent         = 0;
    in_idle_max        = 12;
    out_idle_max       = 12;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset state is a fresh start: one lsb byte with no first flag
    send_component(8'h00, 1'b0);
    send_component(8'hFF, 1'b0);
    send_component(8'h01, 1'b0);
    send_component(8'hFE, 1'b0);
    send_component(8'h80, 1'b0);
    send_component(8'h7F, 1'b0);
    send_component(8'h55, 1'b0);
    send_component(8'hAA, 1'b0);

    // zero length, encrypted: the fourth header byte ends it, then input is ignored
    drain();
    set_config(MODE_LSB4, 2'd1);
    build_payload(32'd0, 1'b1);
    encode_payload(MODE_LSB4, 1'b1);
    carrier_q.push_back({8'hFF, 1'b0});
    send_carrier();

    // pattern-inverted: four flip bits then selected inversions
    drain();
    set_config(MODE_LSBI, 2'd0);
    send_component(8'h01, 1'b1);
    send_component(8'h00, 1'b0);
    send_component(8'hFF, 1'b0);
    send_component(8'hFE, 1'b0);
    send_component(8'h00, 1'b0);
    send_component(8'h02, 1'b0);
    send_component(8'h04, 1'b0);
    send_component(8'h06, 1'b0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      m       = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
      enc_raw = 2'($urandom_range(0, 3));
      set_config(m, enc_raw);
      in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 12;
      out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        // now and then carry on from where the last phase left off
        lead = (k > 0) || ($urandom_range(0, 4) != 0);
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
          repeat ($urandom_range(5, 40))
            carrier_q.push_back({8'($urandom), 1'($urandom_range(0, 15) == 0)});
        end else begin
          build_payload(pick_length(m), enc_raw[0]);
          encode_payload(m, lead);
          if (kind >= 7) begin
            cut = $urandom_range(1, carrier_q.size() - 1);
            while (carrier_q.size() > cut) void'(carrier_q.pop_back());
          end else begin
            repeat ($urandom_range(0, 6)) carrier_q.push_back({8'($urandom), 1'b0});
          end
        end
        send_carrier();
        if ($urandom_range(0, 5) == 0) drain();
      end
      phase++;
    end

    drain();
    repeat (8) @(negedge clk);
    if (sb.expected_q.size() != 0)
      $display("%0d expected bytes never came out", sb.expected_q.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
